FILE: hdl/dtk_pkg.sv
// Package with the shared types and codes of the diverse top-k pose buffer.
`default_nettype none
package dtk_pkg;
    localparam int COORD_BITS = 20;

    localparam logic [1:0] ACT_ATOM   = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] OUT_REPL_NEAR = 3'd0;
    localparam logic [2:0] OUT_NEAR_KEPT = 3'd1;
    localparam logic [2:0] OUT_APPENDED  = 3'd2;
    localparam logic [2:0] OUT_REPL_WORST = 3'd3;
    localparam logic [2:0] OUT_DISCARDED = 3'd4;
    localparam logic [2:0] OUT_READ      = 3'd5;
    localparam logic [2:0] OUT_CLEARED   = 3'd6;

    localparam logic [1:0] CFG_MIN_RMSD = 2'd0;
    localparam logic [1:0] CFG_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_ATOMS    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATOM,
        ST_DECIDE,
        ST_SORT,
        ST_FIND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic signed [19:0] atom_x;
        logic signed [19:0] atom_y;
        logic signed [19:0] atom_z;
        logic        last_atom;
        logic signed [23:0] pose_energy;
        logic [31:0] pose_tag;
        logic [2:0]  read_rank;
    } req_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [2:0]  placed_rank;
        logic [3:0]  entry_count;
        logic signed [23:0] entry_energy;
        logic [31:0] entry_tag;
        logic        entry_valid;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [39:0] data;
    } cfg_t;
endpackage
`default_nettype wire

FILE: hdl/dtk_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface dtk_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/dtk_coord_mem.sv
// Coordinate memory: one row per slot and atom, registered read.
`default_nettype none
module dtk_coord_mem #(
    parameter int DEPTH = 576,
    parameter int AW = 10,
    parameter int DW = 60
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/diverse_top_k_pose_buffer.sv
// Top level of the diverse top-k pose buffer.
// An atom makes one coordinate memory read per held entry.
// The last atom adds a decision pass, a sort of the ranks by energy, and
// a rank search; read and clear go from idle straight to the output state.
// Reset empties the table, sets identity ranks and the register defaults.
// Coordinate memory is not cleared; a request is held until its result is taken.
`default_nettype none
module diverse_top_k_pose_buffer #(
    parameter int MAX_ENTRIES = 8,
    parameter int MAX_ATOMS = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    dtk_if.sink   in_req,
    dtk_if.source out_rsp,
    dtk_if.sink   cfg
);
    localparam int COORD_BITS = dtk_pkg::COORD_BITS;
    localparam int ROWW = 3 * COORD_BITS;
    localparam int SLOTS = MAX_ENTRIES + 1;
    localparam int SW = $clog2(SLOTS);
    localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int ACW = $clog2(MAX_ATOMS + 1);
    localparam int AW = SW + AIW;
    localparam int SUMW = 2 * COORD_BITS + 2 + ACW;

    dtk_pkg::req_t  req_reg;
    dtk_pkg::rsp_t  rsp_reg, rsp_next;
    dtk_pkg::state_t state_reg, state_next;

    logic [39:0] min_rmsd_reg;
    logic [3:0]  capacity_reg;
    logic [6:0]  atoms_reg;

    logic [SW-1:0]   r2s_reg [MAX_ENTRIES];
    logic [SW-1:0]   r2s_next [MAX_ENTRIES];
    logic [SW-1:0]   spare_reg, spare_next;
    logic [CW-1:0]   held_reg, held_next;
    logic [SUMW-1:0] sums_reg [MAX_ENTRIES];
    logic [ACW-1:0]  aidx_reg, aidx_next;
    logic signed [23:0] energy_reg [SLOTS];
    logic [31:0]     tag_reg [SLOTS];
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [SW-1:0]   fresh_reg, fresh_next;
    logic            placed_reg, placed_next;
    logic [2:0]      outc_reg, outc_next;
    logic            wr_e;
    logic [SW-1:0]   wr_slot;
    logic            sums_clear;
    logic            sum_add;
    logic [RW-1:0]   add_rank;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [ROWW-1:0] mem_rdata;

    logic [ACW-1:0]  lim;
    logic [CW-1:0]   cap;
    logic [SUMW-1:0] sq_dist;
    logic [59:0]     prod_thr;
    logic [RW-1:0]   best;
    logic            near;
    logic            sort_swap;

    dtk_coord_mem #(.DEPTH(SLOTS * MAX_ATOMS), .AW(AW), .DW(ROWW)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata({req_reg.atom_x[COORD_BITS-1:0],
        req_reg.atom_y[COORD_BITS-1:0], req_reg.atom_z[COORD_BITS-1:0]} ),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    always_comb
    begin
        if (atoms_reg == 7'd0)
            lim = ACW'(1);
        else if (32'(atoms_reg) > MAX_ATOMS)
            lim = ACW'(MAX_ATOMS);
        else
            lim = ACW'(atoms_reg);
        if (capacity_reg == 4'd0)
            cap = CW'(1);
        else if (32'(capacity_reg) > MAX_ENTRIES)
            cap = CW'(MAX_ENTRIES);
        else
            cap = CW'(capacity_reg);
    end

    // Squared distance of the atom in the request register to the entry row read last cycle.
    always_comb
    begin
        logic signed [COORD_BITS:0] dx, dy, dz;
        logic signed [2*COORD_BITS+1:0] px, py, pz;
        dx = $signed({req_reg.atom_x[COORD_BITS-1], req_reg.atom_x[COORD_BITS-1:0]})
           - $signed({mem_rdata[3*COORD_BITS-1], mem_rdata[3*COORD_BITS-1 -: COORD_BITS]});
        dy = $signed({req_reg.atom_y[COORD_BITS-1], req_reg.atom_y[COORD_BITS-1:0]})
           - $signed({mem_rdata[2*COORD_BITS-1], mem_rdata[2*COORD_BITS-1 -: COORD_BITS]});
        dz = $signed({req_reg.atom_z[COORD_BITS-1], req_reg.atom_z[COORD_BITS-1:0]})
           - $signed({mem_rdata[COORD_BITS-1], mem_rdata[COORD_BITS-1 -: COORD_BITS]});
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
        sq_dist = SUMW'($unsigned(px)) + SUMW'($unsigned(py)) + SUMW'($unsigned(pz));
    end

    always_comb
    begin
        best = '0;
        for (int r = 1; r < MAX_ENTRIES; r++)
        begin
            if (CW'(r) < held_reg && sums_reg[r] < sums_reg[best])
                best = RW'(r);
        end
        prod_thr = min_rmsd_reg * 60'(lim);
        near = (held_reg != '0) && (60'(sums_reg[best]) < prod_thr);
    end

    assign sort_swap = (i_reg != '0) && (energy_reg[r2s_reg[RW'(i_reg - CW'(1))]]
                       > energy_reg[r2s_reg[RW'(i_reg)]]);

    assign in_req.ready = (state_reg == dtk_pkg::ST_IDLE);
    assign cfg.ready = (state_reg == dtk_pkg::ST_IDLE);
    assign out_rsp.valid = (state_reg == dtk_pkg::ST_OUT);
    assign out_rsp.data = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        rsp_next = rsp_reg;
        r2s_next = r2s_reg;
        spare_next = spare_reg;
        held_next = held_reg;
        aidx_next = aidx_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        fresh_next = fresh_reg;
        placed_next = placed_reg;
        outc_next = outc_reg;
        wr_e = 1'b0;
        wr_slot = spare_reg;
        sums_clear = 1'b0;
        sum_add = 1'b0;
        add_rank = RW'(cnt_reg - CW'(1));
        mem_we = 1'b0;
        mem_waddr = AW'(spare_reg) * AW'(MAX_ATOMS) + AW'(aidx_reg);
        mem_raddr = AW'(r2s_reg[RW'(cnt_reg)]) * AW'(MAX_ATOMS) + AW'(aidx_reg);
        case (state_reg)
            dtk_pkg::ST_IDLE:
            begin
                if (in_req.valid)
                begin
                    case (in_req.data.action)
                        dtk_pkg::ACT_ATOM:
                        begin
                            cnt_next = '0;
                            state_next = dtk_pkg::ST_ATOM;
                        end
                        dtk_pkg::ACT_READ:
                        begin
                            rsp_next = '0;
                            rsp_next.outcome = dtk_pkg::OUT_READ;
                            rsp_next.placed_rank = in_req.data.read_rank;
                            rsp_next.entry_count = 4'(held_reg);
                            if (32'(in_req.data.read_rank) < 32'(held_reg))
                            begin
                                rsp_next.entry_valid = 1'b1;
                                rsp_next.entry_energy =
                                    energy_reg[r2s_reg[RW'(in_req.data.read_rank)]];
                                rsp_next.entry_tag =
                                    tag_reg[r2s_reg[RW'(in_req.data.read_rank)]];
                            end
                            state_next = dtk_pkg::ST_OUT;
                        end
                        dtk_pkg::ACT_CLEAR:
                        begin
                            held_next = '0;
                            sums_clear = 1'b1;
                            aidx_next = '0;
                            rsp_next = '0;
                            rsp_next.outcome = dtk_pkg::OUT_CLEARED;
                            state_next = dtk_pkg::ST_OUT;
                        end
                        default:
                        begin
                            state_next = dtk_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dtk_pkg::ST_ATOM:
            begin
                // cnt counts issued reads; rank cnt-1 is summed in the cycle after its read.
                if (aidx_reg < lim)
                begin
                    if (cnt_reg != '0)
                        sum_add = 1'b1;
                    if (cnt_reg == held_reg)
                    begin
                        mem_we = 1'b1;
                        aidx_next = aidx_reg + ACW'(1);
                        if (req_reg.last_atom)
                            state_next = dtk_pkg::ST_DECIDE;
                        else
                            state_next = dtk_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                else if (req_reg.last_atom)
                    state_next = dtk_pkg::ST_DECIDE;
                else
                    state_next = dtk_pkg::ST_IDLE;
            end
            dtk_pkg::ST_DECIDE:
            begin
                placed_next = 1'b0;
                if (near)
                begin
                    if (req_reg.pose_energy < energy_reg[r2s_reg[best]])
                    begin
                        wr_e = 1'b1;
                        spare_next = r2s_reg[best];
                        r2s_next[best] = spare_reg;
                        placed_next = 1'b1;
                        outc_next = dtk_pkg::OUT_REPL_NEAR;
                    end
                    else
                        outc_next = dtk_pkg::OUT_NEAR_KEPT;
                end
                else if (held_reg < cap)
                begin
                    wr_e = 1'b1;
                    spare_next = r2s_reg[RW'(held_reg)];
                    r2s_next[RW'(held_reg)] = spare_reg;
                    held_next = held_reg + CW'(1);
                    placed_next = 1'b1;
                    outc_next = dtk_pkg::OUT_APPENDED;
                end
                else if (req_reg.pose_energy < energy_reg[r2s_reg[RW'(held_reg - CW'(1))]])
                begin
                    wr_e = 1'b1;
                    spare_next = r2s_reg[RW'(held_reg - CW'(1))];
                    r2s_next[RW'(held_reg - CW'(1))] = spare_reg;
                    placed_next = 1'b1;
                    outc_next = dtk_pkg::OUT_REPL_WORST;
                end
                else
                    outc_next = dtk_pkg::OUT_DISCARDED;
                fresh_next = spare_reg;
                cnt_next = CW'(1);
                i_next = CW'(1);
                sums_clear = 1'b1;
                aidx_next = '0;
                state_next = dtk_pkg::ST_SORT;
            end
            dtk_pkg::ST_SORT:
            begin
                // Insertion sort, one compare per cycle.
                if (cnt_reg >= held_reg)
                begin
                    i_next = '0;
                    state_next = dtk_pkg::ST_FIND;
                end
                else if (sort_swap)
                begin
                    r2s_next[RW'(i_reg)] = r2s_reg[RW'(i_reg - CW'(1))];
                    r2s_next[RW'(i_reg - CW'(1))] = r2s_reg[RW'(i_reg)];
                    i_next = i_reg - CW'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                    i_next = cnt_reg + CW'(1);
                end
            end
            dtk_pkg::ST_FIND:
            begin
                rsp_next = '0;
                rsp_next.outcome = outc_reg;
                rsp_next.entry_count = 4'(held_reg);
                for (int r = 0; r < MAX_ENTRIES; r++)
                begin
                    if (placed_reg && CW'(r) < held_reg && r2s_reg[r] == fresh_reg)
                        rsp_next.placed_rank = 3'(r);
                end
                state_next = dtk_pkg::ST_OUT;
            end
            dtk_pkg::ST_OUT:
            begin
                if (out_rsp.ready)
                    state_next = dtk_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dtk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtk_pkg::ST_IDLE;
            min_rmsd_reg <= 40'd1048576;
            capacity_reg <= 4'd8;
            atoms_reg <= 7'd64;
            for (int r = 0; r < MAX_ENTRIES; r++)
            begin
                r2s_reg[r] <= SW'(r);
                sums_reg[r] <= '0;
            end
            spare_reg <= SW'(MAX_ENTRIES);
            held_reg <= '0;
            aidx_reg <= '0;
            cnt_reg <= '0;
            i_reg <= '0;
            placed_reg <= 1'b0;
            outc_reg <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r2s_reg <= r2s_next;
            spare_reg <= spare_next;
            held_reg <= held_next;
            aidx_reg <= aidx_next;
            cnt_reg <= cnt_next;
            i_reg <= i_next;
            placed_reg <= placed_next;
            outc_reg <= outc_next;
            fresh_reg <= fresh_next;
            if (sums_clear)
            begin
                for (int r = 0; r < MAX_ENTRIES; r++)
                    sums_reg[r] <= '0;
            end
            else if (sum_add)
                sums_reg[add_rank] <= sums_reg[add_rank] + sq_dist;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    dtk_pkg::CFG_MIN_RMSD: min_rmsd_reg <= cfg.data.data;
                    dtk_pkg::CFG_CAPACITY: capacity_reg <= cfg.data.data[3:0];
                    dtk_pkg::CFG_ATOMS:    atoms_reg <= cfg.data.data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req.valid && in_req.ready)
            req_reg <= in_req.data;
        rsp_reg <= rsp_next;
        if (wr_e)
        begin
            energy_reg[wr_slot] <= req_reg.pose_energy;
            tag_reg[wr_slot] <= req_reg.pose_tag;
        end
    end

    held_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(MAX_ENTRIES)) else $error("held count above table size");
    sum_only_atom: assert property (@(posedge clk) disable iff (!rst_n)
        sum_add |-> state_reg == dtk_pkg::ST_ATOM) else $error("sum update outside atom pass");
    out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_rsp.valid && !out_rsp.ready |=> $stable(rsp_reg)) else $error("result changed");
    write_once: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> !mem_we) else $error("two coordinate writes in a row");
endmodule
`default_nettype wire
